>>> sv/smsa_pkg.sv
// Shared types and constants for the symbolic mode string apply unit.
// No dependencies; smsa_parser and the top unit refer to this package by scoped names.
package smsa_pkg;

    // Clause limit per string; must stay within 1..63 to fit the 6-bit count.
    localparam logic [5:0] CLAUSE_LIMIT = 6'd32;
    localparam logic [5:0] COUNT_MAX    = 6'd63;

    // Characters of the mode string.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;

    // Who bits: user, group, other.
    localparam logic [2:0] WHO_NONE = 3'b000;
    localparam logic [2:0] WHO_U    = 3'b100;
    localparam logic [2:0] WHO_G    = 3'b010;
    localparam logic [2:0] WHO_O    = 3'b001;
    localparam logic [2:0] WHO_ALL  = 3'b111;

    // Bits that "=" replaces for each class.
    localparam logic [11:0] MASK_U = 12'o4700;
    localparam logic [11:0] MASK_G = 12'o2070;
    localparam logic [11:0] MASK_O = 12'o0007;
    localparam logic [11:0] STICKY = 12'o1000;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_WHO   = 2'd1,
        PH_PERM  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_SET  = 2'd3
    } t_op;

    typedef struct packed {
        logic        emit;
        logic [15:0] new_mode;
        logic        bad_string;
    } t_result;

endpackage

>>> sv/smsa_if.sv
// Valid/ready channel interfaces for the symbolic mode string apply unit.
// Character requests come in on smsa_in_if, mode results leave on smsa_out_if.
interface smsa_in_if;
    logic        valid;
    logic        ready;
    logic        is_first;
    logic [15:0] orig_mode;
    logic [7:0]  ch;

    modport source (output valid, output is_first, output orig_mode, output ch,
                    input ready);
    modport sink   (input valid, input is_first, input orig_mode, input ch,
                    output ready);
endinterface

interface smsa_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] new_mode;
    logic        bad_string;

    modport source (output valid, output new_mode, output bad_string, input ready);
    modport sink   (input valid, input new_mode, input bad_string, output ready);
endinterface

>>> sv/smsa_parser.sv
// Clause parser and mode update: holds the parser state and running mode and
// evaluates one character per step. Depends on smsa_pkg.
module smsa_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_is_first,
    input  logic [15:0]           i_orig_mode,
    input  logic [7:0]            i_ch,
    output smsa_pkg::t_result     o_res
);

    function automatic logic [11:0] perm_bits(input logic [7:0] c, input logic [2:0] w);
        logic [11:0] b;
        b = '0;
        case (c)
            smsa_pkg::CH_R: b = ({12{w[2]}} & 12'o0400) | ({12{w[1]}} & 12'o0040)
                              | ({12{w[0]}} & 12'o0004);
            smsa_pkg::CH_W: b = ({12{w[2]}} & 12'o0200) | ({12{w[1]}} & 12'o0020)
                              | ({12{w[0]}} & 12'o0002);
            smsa_pkg::CH_X: b = ({12{w[2]}} & 12'o0100) | ({12{w[1]}} & 12'o0010)
                              | ({12{w[0]}} & 12'o0001);
            smsa_pkg::CH_S: b = ({12{w[2]}} & 12'o4000) | ({12{w[1]}} & 12'o2000);
            default:        b = smsa_pkg::STICKY;
        endcase
        return b;
    endfunction

    smsa_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_who,   n_who;
    smsa_pkg::t_op    r_op,    n_op;
    logic [11:0]      r_bits,  n_bits;
    logic [15:0]      r_mode,  n_mode;
    logic [5:0]       r_count, n_count;
    logic             r_failed, n_failed;

    // State as seen by this character, after a possible string restart.
    smsa_pkg::t_phase b_phase;
    logic [2:0]       b_who;
    smsa_pkg::t_op    b_op;
    logic [11:0]      b_bits;
    logic [15:0]      b_mode;
    logic [5:0]       b_count;
    logic             b_failed;

    logic [2:0]  eff_who;
    logic [11:0] who_mask;
    logic [15:0] applied_mode;
    logic [5:0]  applied_count;
    logic [15:0] final_mode;
    logic        fail_at_nul;

    always_comb begin
        b_phase  = i_is_first ? smsa_pkg::PH_START : r_phase;
        b_who    = i_is_first ? smsa_pkg::WHO_NONE : r_who;
        b_op     = i_is_first ? smsa_pkg::OP_NONE  : r_op;
        b_bits   = i_is_first ? 12'd0              : r_bits;
        b_mode   = i_is_first ? i_orig_mode        : r_mode;
        b_count  = i_is_first ? 6'd0               : r_count;
        b_failed = i_is_first ? 1'b0               : r_failed;
    end

    // Effect of closing the current clause.
    always_comb begin
        eff_who  = (b_who != smsa_pkg::WHO_NONE) ? b_who : smsa_pkg::WHO_ALL;
        who_mask = ({12{eff_who[2]}} & smsa_pkg::MASK_U)
                 | ({12{eff_who[1]}} & smsa_pkg::MASK_G)
                 | ({12{eff_who[0]}} & smsa_pkg::MASK_O);
        case (b_op)
            smsa_pkg::OP_ADD: applied_mode = b_mode | {4'd0, b_bits};
            smsa_pkg::OP_SUB: applied_mode = b_mode & ~{4'd0, b_bits};
            smsa_pkg::OP_SET: applied_mode = (b_mode & ~{4'd0, who_mask}) | {4'd0, b_bits};
            default:          applied_mode = b_mode;
        endcase
        applied_count = (b_count != smsa_pkg::COUNT_MAX) ? b_count + 6'd1 : b_count;
        fail_at_nul   = b_failed || (b_phase == smsa_pkg::PH_WHO);
        final_mode    = (!b_failed && b_phase == smsa_pkg::PH_PERM) ? applied_mode : b_mode;
    end

    // Next state.
    always_comb begin
        n_phase  = b_phase;
        n_who    = b_who;
        n_op     = b_op;
        n_bits   = b_bits;
        n_mode   = b_mode;
        n_count  = b_count;
        n_failed = b_failed;
        if (i_ch == smsa_pkg::CH_NUL) begin
            n_phase  = smsa_pkg::PH_START;
            n_who    = smsa_pkg::WHO_NONE;
            n_op     = smsa_pkg::OP_NONE;
            n_bits   = 12'd0;
            n_mode   = fail_at_nul ? 16'd0 : final_mode;
            n_count  = 6'd0;
            n_failed = 1'b0;
        end else if (b_failed) begin
            n_failed = 1'b1;
        end else if (b_phase == smsa_pkg::PH_START && b_count >= smsa_pkg::CLAUSE_LIMIT) begin
            n_failed = 1'b1;
        end else if (b_phase != smsa_pkg::PH_PERM) begin
            if (i_ch inside {smsa_pkg::CH_U, smsa_pkg::CH_G, smsa_pkg::CH_O,
                             smsa_pkg::CH_A}) begin
                n_phase = smsa_pkg::PH_WHO;
                case (i_ch)
                    smsa_pkg::CH_U: n_who = b_who | smsa_pkg::WHO_U;
                    smsa_pkg::CH_G: n_who = b_who | smsa_pkg::WHO_G;
                    smsa_pkg::CH_O: n_who = b_who | smsa_pkg::WHO_O;
                    default:        n_who = smsa_pkg::WHO_ALL;
                endcase
            end else if (i_ch inside {smsa_pkg::CH_PLUS, smsa_pkg::CH_MINUS,
                                      smsa_pkg::CH_EQUAL}) begin
                n_phase = smsa_pkg::PH_PERM;
                case (i_ch)
                    smsa_pkg::CH_PLUS:  n_op = smsa_pkg::OP_ADD;
                    smsa_pkg::CH_MINUS: n_op = smsa_pkg::OP_SUB;
                    default:            n_op = smsa_pkg::OP_SET;
                endcase
            end else begin
                n_failed = 1'b1;
            end
        end else if (i_ch inside {smsa_pkg::CH_R, smsa_pkg::CH_W, smsa_pkg::CH_X,
                                  smsa_pkg::CH_S, smsa_pkg::CH_T}) begin
            n_bits = b_bits | perm_bits(i_ch, eff_who);
        end else if (i_ch == smsa_pkg::CH_COMMA) begin
            n_mode  = applied_mode;
            n_count = applied_count;
            n_phase = smsa_pkg::PH_START;
            n_who   = smsa_pkg::WHO_NONE;
            n_op    = smsa_pkg::OP_NONE;
            n_bits  = 12'd0;
        end else begin
            n_failed = 1'b1;
        end
    end

    // Result for the terminating character.
    always_comb begin
        o_res.emit       = (i_ch == smsa_pkg::CH_NUL);
        o_res.new_mode   = fail_at_nul ? 16'd0 : final_mode;
        o_res.bad_string = fail_at_nul;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= smsa_pkg::PH_START;
            r_who    <= smsa_pkg::WHO_NONE;
            r_op     <= smsa_pkg::OP_NONE;
            r_bits   <= 12'd0;
            r_mode   <= 16'd0;
            r_count  <= 6'd0;
            r_failed <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_who    <= n_who;
            r_op     <= n_op;
            r_bits   <= n_bits;
            r_mode   <= n_mode;
            r_count  <= n_count;
            r_failed <= n_failed;
        end
    end

    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_ch == smsa_pkg::CH_NUL |=>
            r_phase == smsa_pkg::PH_START && r_count == 6'd0 && !r_failed)
        else $error("parser not restarted after terminator");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.emit && o_res.bad_string |-> o_res.new_mode == 16'd0)
        else $error("malformed string reported with nonzero mode");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= smsa_pkg::CLAUSE_LIMIT)
        else $error("clause count beyond limit");

endmodule

>>> sv/symbolic_mode_string_apply_unit.sv
// Symbolic mode string apply unit.
// Input channel i_in carries one character request per transfer: ch, plus
// is_first and orig_mode which restart the parser with a new original mode.
// Output channel o_out carries one request per terminating NUL character:
// new_mode (0 when malformed) and bad_string.
// Other characters produce no output; each clause is applied to the running
// mode when its comma or the NUL arrives.
// A NUL in the input register passes through the combinational parser into the
// result register that drives o_out.valid, unless a full result stalls it.
// Throughput: one character per cycle through the parser state registers
// while no NUL waits on a full result. The input stage keeps accepting while
// a result waits on a stalled receiver, until a second NUL reaches the input
// register. When o_out.ready is low the result holds and only a NUL request
// stalls the input side; other characters continue through the parser.
// Reset (i_rst_n low, synchronous) empties both stages and returns the parser
// to clause start with a running mode of zero.
// Depends on smsa_pkg, smsa_if and smsa_parser.
module symbolic_mode_string_apply_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smsa_in_if.sink    i_in,
    smsa_out_if.source o_out
);

    logic        r_in_valid;
    logic        r_in_is_first;
    logic [15:0] r_in_orig_mode;
    logic [7:0]  r_in_ch;

    logic        r_out_valid;
    logic [15:0] r_out_mode;
    logic        r_out_bad;

    smsa_pkg::t_result res;
    logic              out_free;
    logic              advance;

    smsa_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_is_first  (r_in_is_first),
        .i_orig_mode (r_in_orig_mode),
        .i_ch        (r_in_ch),
        .o_res       (res)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && (!res.emit || out_free);
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid      = r_out_valid;
    assign o_out.new_mode   = r_out_mode;
    assign o_out.bad_string = r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_is_first  <= i_in.is_first;
            r_in_orig_mode <= i_in.orig_mode;
            r_in_ch        <= i_in.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.emit) begin
            r_out_mode <= res.new_mode;
            r_out_bad  <= res.bad_string;
        end
    end

    a_held_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_ch))
        else $error("stalled request lost from input stage");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && res.emit |=> r_out_valid)
        else $error("terminator passed without a result");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("empty input stage refuses requests");

endmodule
